// ===== hw/rtl/u8u16_pkg.sv =====
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// No dependencies.
package u8u16_pkg;

    typedef enum logic [1:0] {
        PHASE_IDLE    = 2'd0,
        PHASE_COLLECT = 2'd1,
        PHASE_SKIP    = 2'd2
    } phase_t;

    localparam int unsigned CP_W = 21;

    localparam logic [15:0]     UNIT_REPLACEMENT = 16'hfffd;
    localparam logic [15:0]     UNIT_HI_SURR     = 16'hd800;
    localparam logic [15:0]     UNIT_LO_SURR     = 16'hdc00;
    localparam logic [CP_W-1:0] CP_SURR_LO       = 21'h00d800;
    localparam logic [CP_W-1:0] CP_SURR_HI       = 21'h00e000;
    localparam logic [CP_W-1:0] CP_SUPP          = 21'h010000;
    localparam logic [CP_W-1:0] CP_LIMIT         = 21'h110000;

    // units produced by one byte: count is 0, 1 or 2
    typedef struct packed {
        logic [1:0]  count;
        logic [15:0] unit0;
        logic [15:0] unit1;
    } dec_result_t;

endpackage

// ===== hw/rtl/utf8_to_utf16_transcoder.sv =====
// UTF-8 to UTF-16 transcoder, top level: input register, decoder, result stage.
// Depends on u8u16_pkg, u8u16_decoder, u8u16_out_stage.
//
// Input channel: one UTF-8 byte per item (text_byte), buffer_end marks the
// last byte of a buffer. Output channel: one UTF-16 code unit per item
// (utf16_unit); run_last marks the final unit caused by one input byte.
// Both channels use valid/stall; an item moves when valid is high and
// stall is low.
// A byte accepted into the input register is decoded combinationally and
// loaded into the result register, from which its first unit can be taken.
// Throughput: one byte per cycle while the result register can load. A byte
// that yields a surrogate pair holds the result register until both units are
// taken; a byte that yields no unit passes through without an output item.
// Reset clears the decode state and the valid flags of the input register and result stage.
// When the receiver stalls, the current unit holds, the input register
// fills and in_stall rises; the decode state advances only as bytes move
// into the result register.
module utf8_to_utf16_transcoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  text_byte,
    input  logic        buffer_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] utf16_unit,
    output logic        run_last
);
    import u8u16_pkg::*;

    logic        hold_valid_reg;
    logic [7:0]  byte_reg;
    logic        end_reg;
    logic        can_load;
    logic        advance;
    dec_result_t result;

    assign advance  = hold_valid_reg && can_load;
    assign in_stall = hold_valid_reg && !can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            hold_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= text_byte;
            end_reg  <= buffer_end;
        end
    end

    u8u16_decoder u_decoder (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (advance),
        .text_byte  (byte_reg),
        .buffer_end (end_reg),
        .result     (result)
    );

    u8u16_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .result     (result),
        .can_load   (can_load),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .utf16_unit (utf16_unit),
        .run_last   (run_last)
    );

endmodule

// ===== hw/rtl/u8u16_decoder.sv =====
// Decode state and per-byte decode logic; yields up to two UTF-16 units per item.
// Depends on u8u16_pkg.
module u8u16_decoder (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  logic [7:0]             text_byte,
    input  logic                   buffer_end,
    output u8u16_pkg::dec_result_t result
);
    import u8u16_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [1:0]       remain_reg, remain_next;
    logic [CP_W-1:0]  acc_reg, acc_next;
    logic             stopped_reg, stopped_next;

    logic             cont;
    logic [CP_W-1:0]  acc_shift;
    logic [CP_W-1:0]  cp_off;

    assign cont      = (text_byte[7:6] == 2'b10);
    assign acc_shift = {acc_reg[CP_W-7:0], text_byte[5:0]};
    assign cp_off    = acc_shift - CP_SUPP;

    always_comb
    begin
        phase_next   = phase_reg;
        remain_next  = remain_reg;
        acc_next     = acc_reg;
        stopped_next = stopped_reg;
        result.count = 2'd0;
        result.unit0 = UNIT_REPLACEMENT;
        result.unit1 = UNIT_REPLACEMENT;

        if (!stopped_reg)
        begin
            if (phase_reg == PHASE_COLLECT)
            begin
                if (cont)
                begin
                    acc_next    = acc_shift;
                    remain_next = remain_reg - 2'd1;
                    if (remain_reg == 2'd1)
                    begin
                        phase_next = PHASE_IDLE;
                        if (acc_shift == '0)
                        begin
                            result.count = 2'd0;
                        end
                        else if (acc_shift >= CP_SURR_LO && acc_shift < CP_SURR_HI)
                        begin
                            result.count = 2'd1;
                        end
                        else if (acc_shift < CP_SUPP)
                        begin
                            result.count = 2'd1;
                            result.unit0 = acc_shift[15:0];
                        end
                        else if (acc_shift < CP_LIMIT)
                        begin
                            result.count = 2'd2;
                            result.unit0 = UNIT_HI_SURR | {6'd0, cp_off[19:10]};
                            result.unit1 = UNIT_LO_SURR | {6'd0, cp_off[9:0]};
                        end
                        else
                        begin
                            result.count = 2'd1;
                        end
                    end
                end
                else
                begin
                    phase_next   = PHASE_IDLE;
                    remain_next  = 2'd0;
                    result.count = 2'd1;
                end
            end
            else if (phase_reg == PHASE_SKIP && cont)
            begin
                // swallowed
            end
            else
            begin
                phase_next  = PHASE_IDLE;
                remain_next = 2'd0;
                if (text_byte == 8'd0)
                begin
                    stopped_next = 1'b1;
                end
                else if (!text_byte[7])
                begin
                    result.count = 2'd1;
                    result.unit0 = {8'd0, text_byte};
                end
                else if (text_byte[7:5] == 3'b110)
                begin
                    acc_next    = {16'd0, text_byte[4:0]};
                    remain_next = 2'd1;
                    phase_next  = PHASE_COLLECT;
                end
                else if (text_byte[7:4] == 4'b1110)
                begin
                    acc_next    = {17'd0, text_byte[3:0]};
                    remain_next = 2'd2;
                    phase_next  = PHASE_COLLECT;
                end
                else if (text_byte[7:3] == 5'b11110)
                begin
                    acc_next    = {18'd0, text_byte[2:0]};
                    remain_next = 2'd3;
                    phase_next  = PHASE_COLLECT;
                end
                else
                begin
                    result.count = 2'd1;
                    phase_next   = PHASE_SKIP;
                end
            end
        end

        if (buffer_end)
        begin
            // truncated sequence: no unit was produced on this path
            if (!stopped_next && phase_next == PHASE_COLLECT)
            begin
                result.count = 2'd1;
                result.unit0 = UNIT_REPLACEMENT;
            end
            phase_next   = PHASE_IDLE;
            remain_next  = 2'd0;
            acc_next     = '0;
            stopped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PHASE_IDLE;
            remain_reg  <= 2'd0;
            acc_reg     <= '0;
            stopped_reg <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            remain_reg  <= remain_next;
            acc_reg     <= acc_next;
            stopped_reg <= stopped_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> result.count != 2'd3)
        else $error("decoder produced more than two units");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && buffer_end |=> phase_reg == PHASE_IDLE && !stopped_reg && remain_reg == 2'd0)
        else $error("state not cleared after buffer end");

    a_stopped_silent: assert property (@(posedge clk) disable iff (!rst_n)
        fire && stopped_reg && !buffer_end |-> result.count == 2'd0)
        else $error("output while string stopped");

    a_collect_remain: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PHASE_COLLECT |-> remain_reg != 2'd0)
        else $error("collecting with no bytes remaining");

endmodule

// ===== hw/rtl/u8u16_out_stage.sv =====
// Result register holding up to two units; presents them one per cycle while out_stall is low.
// Depends on u8u16_pkg.
module u8u16_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  u8u16_pkg::dec_result_t result,
    output logic                   can_load,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [15:0]            utf16_unit,
    output logic                   run_last
);
    import u8u16_pkg::*;

    logic        valid_reg;
    logic        two_reg;
    logic        idx_reg;
    logic [15:0] unit0_reg;
    logic [15:0] unit1_reg;
    logic        pop;

    assign out_valid  = valid_reg;
    assign utf16_unit = idx_reg ? unit1_reg : unit0_reg;
    assign run_last   = idx_reg || !two_reg;
    assign pop        = valid_reg && !out_stall;
    assign can_load   = !valid_reg || (pop && run_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            two_reg   <= 1'b0;
            idx_reg   <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= (result.count != 2'd0);
            two_reg   <= (result.count == 2'd2);
            idx_reg   <= 1'b0;
        end
        else if (pop)
        begin
            if (run_last)
            begin
                valid_reg <= 1'b0;
                idx_reg   <= 1'b0;
            end
            else
            begin
                idx_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            unit0_reg <= result.unit0;
            unit1_reg <= result.unit1;
        end
    end

    a_idx_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && idx_reg |-> two_reg)
        else $error("second unit shown for a single-unit item");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> can_load)
        else $error("result register overwritten");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for utf8_to_utf16_transcoder: directed and random UTF-8
// buffers, with expected UTF-16 units predicted per accepted byte and compared in order.
// Depends on u8u16_pkg and the utf8_to_utf16_transcoder RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import u8u16_pkg::*;

    localparam int unsigned STIM_ITEMS  = 1650;
    localparam int unsigned QUIET_TAIL  = 150;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned IDLE_LIMIT  = 3000;
    localparam int unsigned MAX_PRINTS  = 100;

    typedef struct {
        logic [7:0] text;
        logic       eob;
    } byte_item_t;

    typedef struct {
        logic [15:0] code_unit;
        logic        last;
    } unit_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  text_byte = 8'h00;
    logic        buffer_end = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] utf16_unit;
    logic        run_last;

    byte_item_t pending_bytes[$];
    unit_item_t expected_units[$];

    phase_t      dec_phase = PHASE_IDLE;
    logic [1:0]  conts_left = 2'd0;
    logic [20:0] cp_acc = 21'd0;
    logic        str_stopped = 1'b0;

    int unsigned mismatches = 0;
    int unsigned units_taken = 0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned idle_cycles = 0;
    logic        quiet = 1'b0;
    logic        calm_in = 1'b0;
    logic        calm_out = 1'b0;
    logic        hold_done = 1'b0;
    byte_item_t  next_item;
    unit_item_t  want;

    utf8_to_utf16_transcoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .text_byte  (text_byte),
        .buffer_end (buffer_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .utf16_unit (utf16_unit),
        .run_last   (run_last)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
        begin
            $display("%0t ERROR: %s", $realtime, what);
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic eob);
        logic [15:0] units [2];
        logic [20:0] ofs;
        int          n;
        logic        cont;
        n = 0;
        cont = (b[7:6] == 2'b10);
        if (!str_stopped)
        begin
            if (dec_phase == PHASE_COLLECT)
            begin
                if (cont)
                begin
                    cp_acc = {cp_acc[14:0], b[5:0]};
                    conts_left = conts_left - 2'd1;
                    if (conts_left == 2'd0)
                    begin
                        dec_phase = PHASE_IDLE;
                        if (cp_acc == 21'd0)
                        begin
                            // overlong NUL: nothing out
                        end
                        else if (cp_acc >= CP_SURR_LO && cp_acc < CP_SURR_HI)
                        begin
                            units[n] = UNIT_REPLACEMENT;
                            n++;
                        end
                        else if (cp_acc < CP_SUPP)
                        begin
                            units[n] = cp_acc[15:0];
                            n++;
                        end
                        else if (cp_acc < CP_LIMIT)
                        begin
                            ofs = cp_acc - CP_SUPP;
                            units[0] = UNIT_HI_SURR | {6'd0, ofs[19:10]};
                            units[1] = UNIT_LO_SURR | {6'd0, ofs[9:0]};
                            n = 2;
                        end
                        else
                        begin
                            units[n] = UNIT_REPLACEMENT;
                            n++;
                        end
                    end
                end
                else
                begin
                    dec_phase = PHASE_IDLE;
                    conts_left = 2'd0;
                    units[n] = UNIT_REPLACEMENT;
                    n++;
                end
            end
            else if (dec_phase == PHASE_SKIP && cont)
            begin
                // continuation after a bad lead is dropped
            end
            else
            begin
                dec_phase = PHASE_IDLE;
                conts_left = 2'd0;
                if (b == 8'h00)
                begin
                    str_stopped = 1'b1;
                end
                else if (!b[7])
                begin
                    units[n] = {8'h00, b};
                    n++;
                end
                else if (b[7:5] == 3'b110)
                begin
                    cp_acc = {16'd0, b[4:0]};
                    conts_left = 2'd1;
                    dec_phase = PHASE_COLLECT;
                end
                else if (b[7:4] == 4'b1110)
                begin
                    cp_acc = {17'd0, b[3:0]};
                    conts_left = 2'd2;
                    dec_phase = PHASE_COLLECT;
                end
                else if (b[7:3] == 5'b11110)
                begin
                    cp_acc = {18'd0, b[2:0]};
                    conts_left = 2'd3;
                    dec_phase = PHASE_COLLECT;
                end
                else
                begin
                    units[n] = UNIT_REPLACEMENT;
                    n++;
                    dec_phase = PHASE_SKIP;
                end
            end
        end
        if (eob)
        begin
            if (!str_stopped && dec_phase == PHASE_COLLECT)
            begin
                units[n] = UNIT_REPLACEMENT;
                n++;
            end
            dec_phase = PHASE_IDLE;
            conts_left = 2'd0;
            cp_acc = 21'd0;
            str_stopped = 1'b0;
        end
        for (int i = 0; i < n; i++)
        begin
            expected_units.insert(expected_units.size(), '{units[i], (i == n - 1)});
        end
    endtask

    task automatic queue_buffer(input logic [7:0] bytes[$]);
        for (int i = 0; i < bytes.size(); i++)
        begin
            pending_bytes.insert(pending_bytes.size(),
                                 '{bytes[i], (i == bytes.size() - 1)});
        end
    endtask

    task automatic build_random_buffers();
        logic [7:0]  bytes[$];
        int unsigned kind;
        int unsigned len;
        int unsigned conts;
        while (pending_bytes.size() < STIM_ITEMS)
        begin
            bytes.delete();
            repeat ($urandom_range(1, 30))
            begin
                kind = $urandom_range(0, 99);
                if (kind < 30)
                begin
                    bytes.insert(bytes.size(), 8'($urandom_range(1, 127)));
                end
                else if (kind < 80)
                begin
                    len = (kind < 50) ? 2 : (kind < 65) ? 3 : 4;
                    case (len)
                        2: bytes.insert(bytes.size(), 8'hc0 | 8'($urandom_range(0, 31)));
                        3: bytes.insert(bytes.size(), 8'he0 | 8'($urandom_range(0, 15)));
                        default: bytes.insert(bytes.size(), 8'hf0 | 8'($urandom_range(0, 7)));
                    endcase
                    repeat (len - 1)
                        bytes.insert(bytes.size(), 8'h80 | 8'($urandom_range(0, 63)));
                end
                else if (kind < 88)
                begin
                    bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
                end
                else if (kind < 96)
                begin
                    len = $urandom_range(2, 4);
                    conts = $urandom_range(0, len - 2);
                    bytes.insert(bytes.size(),
                                 (len == 2) ? 8'hc1 : (len == 3) ? 8'he5 : 8'hf2);
                    repeat (conts)
                        bytes.insert(bytes.size(), 8'h80 | 8'($urandom_range(0, 63)));
                end
                else if (kind < 97)
                begin
                    bytes.insert(bytes.size(), 8'h00);
                end
                else
                begin
                    bytes.insert(bytes.size(), 8'hc0);
                    bytes.insert(bytes.size(), 8'h80);
                end
            end
            queue_buffer(bytes);
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            quiet <= (pending_bytes.size() < QUIET_TAIL);
            if (in_valid && !in_stall)
            begin
                decode_byte(text_byte, buffer_end);
            end
            if (!in_valid || !in_stall)
            begin
                if ($urandom_range(0, 199) == 0)
                begin
                    calm_in = ~calm_in;
                end
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_bytes.size() > 0)
                begin
                    next_item = pending_bytes.pop_front();
                    text_byte <= next_item.text;
                    buffer_end <= next_item.eob;
                    in_valid <= 1'b1;
                    if (!quiet && !calm_in && $urandom_range(0, 7) == 0)
                    begin
                        send_gap = $urandom_range(1, 12);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ($urandom_range(0, 199) == 0)
            begin
                calm_out = ~calm_out;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!hold_done && units_taken >= 300)
            begin
                hold_done = 1'b1;
                stall_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else if (!quiet && !calm_out && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 11);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            units_taken <= units_taken + 1;
            if (expected_units.size() == 0)
            begin
                report_mismatch($sformatf("unexpected unit %h last %b", utf16_unit, run_last));
            end
            else
            begin
                want = expected_units.pop_front();
                if (utf16_unit !== want.code_unit)
                begin
                    report_mismatch($sformatf("utf16_unit %h, expected %h",
                                              utf16_unit, want.code_unit));
                end
                if (run_last !== want.last)
                begin
                    report_mismatch($sformatf("run_last %b, expected %b on unit %h",
                                              run_last, want.last, want.code_unit));
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("utf8_to_utf16_transcoder: mismatch");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        // ASCII extremes, 2/3/4-byte forms, surrogate, above U+10FFFF, overlong NUL,
        // bad leads, broken sequence ending in NUL, truncation at buffer end
        queue_buffer('{8'h7f, 8'hc2, 8'ha9, 8'he2, 8'h82, 8'hac, 8'hf0, 8'h9f, 8'h98,
                       8'h80, 8'hed, 8'ha0, 8'h80, 8'hf4, 8'h90, 8'h80, 8'h80, 8'hc0,
                       8'h80, 8'h80, 8'h80, 8'h01, 8'hff, 8'hc3, 8'h00, 8'he2, 8'h82});
        // NUL at a sequence start silences the rest of the buffer
        queue_buffer('{8'h00, 8'h41, 8'hc3});
        build_random_buffers();

        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        do @(posedge clk); while (pending_bytes.size() != 0 || in_valid);
        while (expected_units.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("utf8_to_utf16_transcoder: match");
        end
        else
        begin
            $display("utf8_to_utf16_transcoder: mismatch");
        end
        $finish;
    end

endmodule
